FILE: rtl/per_step_zscore_normalizer_assert.svh
// ---------------------------------------------------------------------------
// per_step_zscore_normalizer_assert
// Assertion helpers for the RTL modules, included by pszn_back.
// ---------------------------------------------------------------------------
`ifndef PER_STEP_ZSCORE_NORMALIZER_ASSERT_SVH
`define PER_STEP_ZSCORE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSZN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSZN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/pszn_pkg.sv
// ---------------------------------------------------------------------------
// pszn_pkg
// Shared constants, operation codes and structs of the z-score normalizer.
// ---------------------------------------------------------------------------
`default_nettype none

package pszn_pkg;

  localparam int MAX_MISSIONS = 64;
  localparam int MAX_STEPS    = 256;
  localparam int MI_W         = $clog2(MAX_MISSIONS);
  localparam int ST_W         = $clog2(MAX_STEPS);
  localparam int ADDR_W       = MI_W + ST_W;

  // Serial divider: 72-bit dividend, 31-bit divisor.
  localparam int DIV_W  = 72;
  localparam int DIVR_W = 31;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FINISH,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MI_W-1:0]   mission_index;
    logic [ST_W-1:0]   step_index;
    logic [31:0]       sample_value;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/pszn_front.sv
// ---------------------------------------------------------------------------
// pszn_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pszn_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           kind,
  input  wire logic [5:0]           mission_index,
  input  wire logic [7:0]           step_index,
  input  wire logic signed [31:0]   sample_value,
  output logic                      q_valid,
  output pszn_pkg::q_item_t         q_item,
  input  wire logic                 q_pop
);
  import pszn_pkg::*;

  q_item_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_item_t    item_in;
  logic       push;

  always_comb begin
    unique case (kind)
      KIND_LOAD:   item_in.op = OP_LOAD;
      KIND_FINISH: item_in.op = OP_FINISH;
      KIND_READ:   item_in.op = OP_READ;
      default:     item_in.op = OP_NONE;
    endcase
    item_in.mission_index = mission_index;
    item_in.step_index    = step_index;
    item_in.sample_value  = sample_value;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pszn_div.sv
// ---------------------------------------------------------------------------
// pszn_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module pszn_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pszn_pkg::div_req_t req,
  output pszn_pkg::div_rsp_t rsp
);
  import pszn_pkg::*;

  logic [DIV_W-1:0]  quo;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DIVR_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= '0;
      end else if (busy) begin
        rem <= fits ? DIVR_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVR_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

FILE: rtl/pszn_back.sv
// ---------------------------------------------------------------------------
// pszn_back
// Executes queued items: sample store, statistics walk, z-score reads.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_step_zscore_normalizer_assert.svh"

module pszn_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  pszn_pkg::q_item_t        q_item,
  output logic                     q_pop,
  input  wire logic [6:0]          n_cnt,
  input  wire logic [8:0]          s_cnt,
  input  wire logic                cfg_clear,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_z,
  output logic signed [31:0]       out_mean,
  output logic [30:0]              out_dev,
  output logic                     out_dz,
  output logic                     out_rdy
);
  import pszn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_SUMWAIT, S_MSTART, S_MWAIT, S_SQ, S_SQWAIT,
    S_VSTART, S_VWAIT, S_SQRT, S_STORE, S_RD, S_ZWAIT
  } state_t;

  state_t state;

  logic [31:0] smem [MAX_MISSIONS*MAX_STEPS];
  logic [31:0] mmem [MAX_STEPS];
  logic [30:0] dmem [MAX_STEPS];
  logic [31:0] smem_q;
  logic [31:0] mmem_q;
  logic [30:0] dmem_q;
  logic              smem_re;
  logic [ADDR_W-1:0] smem_raddr;
  logic              smem_we;
  logic              stat_re;
  logic              stat_we;

  logic              ready;
  logic [MI_W-1:0]   m;
  logic [ST_W-1:0]   t;
  logic signed [37:0] sum;
  logic              sum_v;
  logic signed [31:0] mean;
  logic              sq_v1;
  logic              a_v;
  logic              p_v;
  logic [31:0]       a_reg;
  logic [63:0]       prod;
  logic [69:0]       sumsq;
  logic [69:0]       var_sh;
  logic [37:0]       rem;
  logic [35:0]       root;
  logic [5:0]        k;
  logic              neg;
  logic              in_range;
  logic              is_load;

  logic [37:0]       sum_abs;
  logic [32:0]       d_sq;
  logic [32:0]       d_rd;
  logic [39:0]       rem_sh;
  logic [39:0]       trial;
  logic [30:0]       dev_sat;
  logic [DIV_W-1:0]  qv;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pszn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q_pop    = (state == S_IDLE) && q_valid && !out_valid;
  assign in_range = ({1'b0, q_item.mission_index} < n_cnt) &&
                    ({1'b0, q_item.step_index} < s_cnt);
  assign is_load  = q_pop && (q_item.op == OP_LOAD);
  assign smem_we  = is_load;
  assign stat_re  = q_pop && (q_item.op == OP_READ) && ready && in_range;
  assign stat_we  = (state == S_STORE);

  always_comb begin
    smem_re    = 1'b0;
    smem_raddr = {m, t};
    if (state == S_SUM || state == S_SQ) begin
      smem_re = 1'b1;
    end else if (stat_re) begin
      smem_re    = 1'b1;
      smem_raddr = {q_item.mission_index, q_item.step_index};
    end
  end

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[{q_item.mission_index, q_item.step_index}] <= q_item.sample_value;
    end
    if (smem_re) begin
      smem_q <= smem[smem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      mmem[t] <= mean;
      dmem[t] <= dev_sat;
    end
    if (stat_re) begin
      mmem_q <= mmem[q_item.step_index];
      dmem_q <= dmem[q_item.step_index];
    end
  end

  assign sum_abs = sum[37] ? 38'(-sum) : 38'(sum);
  assign d_sq    = {smem_q[31], smem_q} - {mean[31], mean};
  assign d_rd    = {smem_q[31], smem_q} - {mmem_q[31], mmem_q};
  assign rem_sh  = {rem, var_sh[69:68]};
  assign trial   = {2'b00, root, 2'b01};
  assign dev_sat = (root > 36'h07FFFFFFF) ? 31'h7FFFFFFF : root[30:0];
  assign qv      = div_rsp.quotient;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(sum_abs);
    div_req.divisor  = DIVR_W'(n_cnt);
    unique case (state)
      S_MSTART: div_req.start = 1'b1;
      S_VSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sumsq);
      end
      S_RD: begin
        div_req.start    = (dmem_q != 31'd0);
        div_req.dividend = DIV_W'({(d_rd[32] ? 32'(-d_rd) : d_rd[31:0]), 16'h0000});
        div_req.divisor  = dmem_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // Mean-pass sum, and the squared-difference pipeline: abs, square, accumulate.
    if (sum_v) begin
      sum <= sum + 38'(signed'(smem_q));
    end
    if (sq_v1) begin
      a_reg <= d_sq[32] ? 32'(-d_sq) : d_sq[31:0];
    end
    if (a_v) begin
      prod <= a_reg * a_reg;
    end
    if (p_v) begin
      sumsq <= sumsq + 70'(prod);
    end

    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b0;
      out_valid <= 1'b0;
      sum_v     <= 1'b0;
      sq_v1     <= 1'b0;
      a_v       <= 1'b0;
      p_v       <= 1'b0;
    end else begin
      sum_v <= (state == S_SUM);
      sq_v1 <= (state == S_SQ);
      a_v   <= sq_v1;
      p_v   <= a_v;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_clear) begin
        ready <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            out_z    <= '0;
            out_mean <= '0;
            out_dev  <= '0;
            out_dz   <= 1'b0;
            out_rdy  <= 1'b0;
            unique case (q_item.op)
              OP_LOAD: begin
                ready     <= 1'b0;
                out_valid <= 1'b1;
              end
              OP_FINISH: begin
                t     <= '0;
                m     <= '0;
                sum   <= '0;
                state <= S_SUM;
              end
              OP_READ: begin
                if (ready && in_range) begin
                  state <= S_RD;
                end else begin
                  out_rdy   <= ready;
                  out_valid <= 1'b1;
                end
              end
              default: begin
                out_rdy   <= ready;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SUM: begin
          if ({1'b0, m} == n_cnt - 7'd1) begin
            state <= S_SUMWAIT;
          end else begin
            m <= m + 1'b1;
          end
        end
        S_SUMWAIT: state <= S_MSTART;
        S_MSTART:  state <= S_MWAIT;
        S_MWAIT: begin
          if (div_rsp.done) begin
            mean  <= sum[37] ? 32'(-qv) : qv[31:0];
            m     <= '0;
            sumsq <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if ({1'b0, m} == n_cnt - 7'd1) begin
            state <= S_SQWAIT;
          end else begin
            m <= m + 1'b1;
          end
        end
        S_SQWAIT: begin
          if (!sq_v1 && !a_v && !p_v) begin
            state <= S_VSTART;
          end
        end
        S_VSTART: state <= S_VWAIT;
        S_VWAIT: begin
          if (div_rsp.done) begin
            var_sh <= qv[69:0];
            rem    <= '0;
            root   <= '0;
            k      <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          // One root bit per cycle, two variance bits consumed.
          if (rem_sh >= trial) begin
            rem  <= 38'(rem_sh - trial);
            root <= {root[34:0], 1'b1};
          end else begin
            rem  <= rem_sh[37:0];
            root <= {root[34:0], 1'b0};
          end
          var_sh <= {var_sh[67:0], 2'b00};
          k      <= k + 1'b1;
          if (k == 6'd34) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if ({1'b0, t} == s_cnt - 9'd1) begin
            ready     <= 1'b1;
            out_rdy   <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            t     <= t + 1'b1;
            m     <= '0;
            sum   <= '0;
            state <= S_SUM;
          end
        end
        S_RD: begin
          out_mean <= mmem_q;
          out_dev  <= dmem_q;
          out_rdy  <= 1'b1;
          neg      <= d_rd[32];
          if (dmem_q == 31'd0) begin
            out_dz    <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_ZWAIT;
          end
        end
        S_ZWAIT: begin
          if (div_rsp.done) begin
            if (neg) begin
              out_z <= (qv >= DIV_W'(32'h80000000)) ? 32'h80000000 : 32'(-qv);
            end else begin
              out_z <= (qv > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : qv[31:0];
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSZN_ASSERT_IMPL(a_div_idle_on_start, div_req.start, !div_rsp.busy)
  `PSZN_ASSERT_IMPL(a_dz_forces_zero, out_valid && out_dz, out_z == 32'sd0 && out_rdy)
  `PSZN_ASSERT_IMPL(a_m_in_range, state == S_SUM || state == S_SQ, {1'b0, m} < n_cnt)
  `PSZN_ASSERT_NEXT(a_load_clears_ready, is_load, !ready)

endmodule

`default_nettype wire

FILE: rtl/per_step_zscore_normalizer.sv
// ---------------------------------------------------------------------------
// per_step_zscore_normalizer
// Per-step mean, deviation and z-score over a mission by step sample store.
// ---------------------------------------------------------------------------
//   channel   handshake            payload
//   input     in_valid/in_ready    kind, mission_index, step_index, sample_value
//   result    out_valid/out_ready  normalized_value, step_mean, step_deviation,
//                                  deviation_zero, stats_ready
//   config    APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// The back end pops an item only when idle and no result waits. A load, an unknown
// item or an unserved read is answered from the idle state; a zero-deviation read
// skips the divider; other reads run the 72-step serial divider. A finish makes two
// passes over the sample port, two divider runs and a 35-step square root per step.
// Reset is synchronous and clears control state only. A two-entry queue takes
// items while not full, as the back end works or its result waits on out_ready.
`default_nettype none

module per_step_zscore_normalizer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [5:0]         mission_index,
  input  wire logic [7:0]         step_index,
  input  wire logic signed [31:0] sample_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      normalized_value,
  output logic signed [31:0]      step_mean,
  output logic [30:0]             step_deviation,
  output logic                    deviation_zero,
  output logic                    stats_ready,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pszn_pkg::*;

  logic [6:0] missions_in_use;
  logic [8:0] steps_in_use;
  logic [6:0] n_cnt;
  logic [8:0] s_cnt;
  logic       cfg_we;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_item;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {23'd0, steps_in_use} : {25'd0, missions_in_use};

  always_ff @(posedge clk) begin
    if (rst) begin
      missions_in_use <= 7'd64;
      steps_in_use    <= 9'd256;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        steps_in_use <= pwdata[8:0];
      end else begin
        missions_in_use <= pwdata[6:0];
      end
    end
  end

  // Out-of-range counts are clamped to one and to the store size.
  always_comb begin
    n_cnt = missions_in_use;
    if (missions_in_use == 7'd0) begin
      n_cnt = 7'd1;
    end else if (missions_in_use > 7'(MAX_MISSIONS)) begin
      n_cnt = 7'(MAX_MISSIONS);
    end
    s_cnt = steps_in_use;
    if (steps_in_use == 9'd0) begin
      s_cnt = 9'd1;
    end else if (steps_in_use > 9'(MAX_STEPS)) begin
      s_cnt = 9'(MAX_STEPS);
    end
  end

  pszn_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .mission_index (mission_index),
    .step_index    (step_index),
    .sample_value  (sample_value),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  pszn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .n_cnt     (n_cnt),
    .s_cnt     (s_cnt),
    .cfg_clear (cfg_we),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_z     (normalized_value),
    .out_mean  (step_mean),
    .out_dev   (step_deviation),
    .out_dz    (deviation_zero),
    .out_rdy   (stats_ready)
  );

endmodule

`default_nettype wire
